// ===== hw/rtl/tst_pkg.sv =====
`timescale 1ns / 1ps

package tst_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SRC_W          = 2;
  localparam int SPD_W          = 13;
  localparam int ACC_W          = 10;
  localparam int SNAP_W         = 10;
  localparam int TOL_W          = 14;
  localparam int HOLD_W         = 16;
  localparam int CFG_IDX_W      = 3;
  // braking time carries 8 fraction bits
  localparam int T_FRAC         = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_MAX_SPEED    = 3'd1,
    REG_ACCELERATION = 3'd2,
    REG_SNAP_WINDOW  = 3'd3,
    REG_TOLERANCE    = 3'd4,
    REG_BASE_ANGLE   = 3'd5,
    REG_HOLD_TICKS   = 3'd6
  } cfg_reg_e;

  typedef enum logic [SRC_W-1:0] {
    SRC_NONE  = 2'd0,
    SRC_TRACK = 2'd1,
    SRC_FORCE = 2'd2
  } aim_src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_ACC,
    ST_MUL_DIST,
    ST_MUL_RHS,
    ST_UPD,
    ST_OUT
  } tst_state_e;

endpackage

// ===== hw/rtl/tst_in_if.sv =====
`timescale 1ns / 1ps

interface tst_in_if import tst_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [SRC_W-1:0]      aim_source;
  logic [ANGLE_BITS-1:0] aim_angle;
  logic                  restart_hold;

  modport source (output valid, aim_source, aim_angle, restart_hold, input ready);
  modport sink   (input valid, aim_source, aim_angle, restart_hold, output ready);
endinterface

// ===== hw/rtl/tst_out_if.sv =====
`timescale 1ns / 1ps

interface tst_out_if import tst_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [ANGLE_BITS-1:0]        turret_angle;
  logic [SPD_W-1:0]             turret_speed;
  logic signed [ANGLE_BITS-1:0] remaining_error;
  logic                         on_target;
  logic                         at_base;
  logic                         accelerating;

  modport source (output valid, turret_angle, turret_speed, remaining_error, on_target,
                  at_base, accelerating, input ready);
  modport sink   (input valid, turret_angle, turret_speed, remaining_error, on_target,
                  at_base, accelerating, output ready);
endinterface

// ===== hw/rtl/turret_slew_tracker.sv =====
`timescale 1ns / 1ps
// enable set: a 21-step restoring divide for the braking time, three passes through
// one shared multiplier, then an update state; zero acceleration skips the divide,
// enable clear runs only the update; the next word waits until the result is taken
// reset: async active low; state, hold countdown, configuration, angle, speed, error
// and divide counter reset; the datapath registers and output flags have no reset

module turret_slew_tracker import tst_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int CFG_W = (ANGLE_BITS > HOLD_W) ? ANGLE_BITS : HOLD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tst_in_if.sink               in_i,
  tst_out_if.source            out_o
);

  localparam int AB    = ANGLE_BITS;
  localparam int QW    = SPD_W + T_FRAC;          // braking time quotient
  localparam int YW    = SPD_W + T_FRAC + 1;      // 512*speed - accel*t
  localparam int DW    = QW + YW;                 // braking distance
  localparam int MAW   = (AB > YW) ? AB : YW;
  localparam int MBW   = QW + 1;
  localparam int PW    = MAW + MBW;
  localparam int CW    = PW + T_FRAC + 1;
  localparam int CNT_W = $clog2(QW);
  localparam int HCW   = HOLD_W + 1;
  localparam int MW    = (AB > TOL_W) ? AB : TOL_W;
  localparam int SSW   = SPD_W + 2;

  function automatic logic [AB-1:0] mag_f(input logic [AB-1:0] v);
    mag_f = v[AB-1] ? (~v + 1'b1) : v;
  endfunction

  // configuration
  logic              enable_q;
  logic [SPD_W-1:0]  max_speed_q;
  logic [ACC_W-1:0]  accel_q;
  logic [SNAP_W-1:0] snap_q;
  logic [TOL_W-1:0]  tol_q;
  logic [AB-1:0]     base_q;
  logic [HOLD_W-1:0] hold_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      max_speed_q  <= '0;
      accel_q      <= '0;
      snap_q       <= SNAP_W'(1);
      tol_q        <= '0;
      base_q       <= '0;
      hold_ticks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:       enable_q     <= cfg_data_i[0];
        REG_MAX_SPEED:    max_speed_q  <= cfg_data_i[SPD_W-1:0];
        REG_ACCELERATION: accel_q      <= cfg_data_i[ACC_W-1:0];
        REG_SNAP_WINDOW:  snap_q       <= cfg_data_i[SNAP_W-1:0];
        REG_TOLERANCE:    tol_q        <= cfg_data_i[TOL_W-1:0];
        REG_BASE_ANGLE:   base_q       <= cfg_data_i[AB-1:0];
        REG_HOLD_TICKS:   hold_ticks_q <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  tst_state_e state_q, state_d;

  logic [AB-1:0]     cur_q, cur_d;
  logic [SPD_W-1:0]  speed_q, speed_d;
  logic [AB-1:0]     err_q, err_d;
  logic [HCW-1:0]    hold_q, hold_rl, hold_d;
  logic [AB-1:0]     target_q, target_d;
  logic [ACC_W-1:0]  rem_q, rem_d;
  logic [QW-1:0]     quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PW-1:0]     product_q;
  logic [DW-1:0]     dist_q;
  logic              on_tgt_q, on_tgt_d;
  logic              at_base_q, at_base_d;
  logic              acc_q, acc_d;

  logic              in_acc;
  logic              div_bit;
  logic [ACC_W:0]    trial;
  logic [YW-1:0]     y_val;
  logic [MAW-1:0]    mul_a;
  logic [MBW-1:0]    mul_b;

  logic [AB-1:0]     nd, nd_mag, step_m;
  logic [SSW-1:0]    spd_raw;
  logic [SPD_W-1:0]  spd_clamp;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = (state_q == ST_OUT);

  // hold countdown runs on every tick, enabled or not
  always_comb begin
    hold_rl = in_i.restart_hold ? {1'b0, hold_ticks_q} : hold_q;
    hold_d  = hold_rl[HCW-1] ? hold_rl : hold_rl - 1'b1;
    if ((in_i.aim_source == SRC_TRACK) || (in_i.aim_source == SRC_FORCE)) begin
      target_d = in_i.aim_angle;
    end else if (hold_d[HCW-1]) begin
      target_d = base_q;
    end else begin
      target_d = cur_q;
    end
  end

  // one restoring divide step
  always_comb begin
    trial   = {rem_q, quo_q[QW-1]};
    div_bit = (trial >= {1'b0, accel_q});
    rem_d   = div_bit ? ACC_W'(trial - {1'b0, accel_q}) : trial[ACC_W-1:0];
  end

  // shared multiplier operand select
  assign y_val = {speed_q, {(T_FRAC + 1){1'b0}}} - product_q[YW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL_ACC: begin
        mul_a = MAW'(accel_q);
        mul_b = MBW'(quo_q);
      end
      ST_MUL_DIST: begin
        mul_a = MAW'(y_val);
        mul_b = MBW'(quo_q);
      end
      ST_MUL_RHS: begin
        mul_a = MAW'(mag_f(err_q));
        mul_b = {1'b0, quo_q} + MBW'(1 << T_FRAC);
      end
      default: ;
    endcase
  end

  // tick update
  always_comb begin
    nd      = target_q - cur_q;
    nd_mag  = mag_f(nd);
    acc_d   = enable_q && (CW'(dist_q) < {product_q, {(T_FRAC + 1){1'b0}}});
    spd_raw = acc_d ? ({2'b00, speed_q} + SSW'(accel_q))
                    : ({2'b00, speed_q} - SSW'(accel_q));
    if (spd_raw[SSW-1]) begin
      spd_clamp = '0;
    end else if (spd_raw > {2'b00, max_speed_q}) begin
      spd_clamp = max_speed_q;
    end else begin
      spd_clamp = spd_raw[SPD_W-1:0];
    end
    step_m = (MW'(spd_clamp) < MW'(nd_mag)) ? AB'(spd_clamp) : nd_mag;

    cur_d   = cur_q;
    speed_d = speed_q;
    err_d   = err_q;
    if (enable_q) begin
      if (MW'(nd_mag) < MW'(snap_q)) begin
        cur_d   = target_q;
        err_d   = '0;
        speed_d = '0;
      end else begin
        speed_d = spd_clamp;
        if (nd[AB-1] || (nd == '0)) begin
          cur_d = cur_q - step_m;
          err_d = nd + step_m;
        end else begin
          cur_d = cur_q + step_m;
          err_d = nd - step_m;
        end
      end
    end
    on_tgt_d  = MW'(mag_f(err_d)) < MW'(tol_q);
    at_base_d = MW'(mag_f(base_q - cur_d)) < MW'(snap_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (!enable_q) begin
            state_d = ST_UPD;
          end else if (accel_q == '0) begin
            state_d = ST_MUL_ACC;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV:      if (cnt_q == '0) state_d = ST_MUL_ACC;
      ST_MUL_ACC:  state_d = ST_MUL_DIST;
      ST_MUL_DIST: state_d = ST_MUL_RHS;
      ST_MUL_RHS:  state_d = ST_UPD;
      ST_UPD:      state_d = ST_OUT;
      ST_OUT:      if (out_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      speed_q <= '0;
      err_q   <= '0;
      hold_q  <= '1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        hold_q <= hold_d;
        cnt_q  <= CNT_W'(QW - 1);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == ST_UPD) begin
        cur_q   <= cur_d;
        speed_q <= speed_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q <= target_d;
      rem_q    <= '0;
      // zero acceleration gives zero braking time
      quo_q    <= (accel_q == '0) ? '0 : {speed_q, {T_FRAC{1'b0}}};
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], div_bit};
    end
    if ((state_q == ST_MUL_ACC) || (state_q == ST_MUL_DIST) || (state_q == ST_MUL_RHS)) begin
      product_q <= mul_a * mul_b;
    end
    if (state_q == ST_MUL_RHS) begin
      dist_q <= product_q[DW-1:0];
    end
    if (state_q == ST_UPD) begin
      on_tgt_q  <= on_tgt_d;
      at_base_q <= at_base_d;
      acc_q     <= acc_d;
    end
  end

  assign out_o.turret_angle    = cur_q;
  assign out_o.turret_speed    = speed_q;
  assign out_o.remaining_error = err_q;
  assign out_o.on_target       = on_tgt_q;
  assign out_o.at_base         = at_base_q;
  assign out_o.accelerating    = acc_q;

endmodule

// ===== hw/rtl/tst_checker.sv =====
`timescale 1ns / 1ps

module tst_checker #(
  parameter int ANGLE_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [ANGLE_BITS-1:0] turret_angle_i
);

  // one word in flight: never ready while a result waits
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> (!in_ready_i && !out_valid_i))
    else $error("not busy after a word was accepted");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> (!out_valid_i && in_ready_i))
    else $error("result repeated or block not idle after result taken");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(turret_angle_i)))
    else $error("stalled result changed");

endmodule

bind turret_slew_tracker tst_checker #(
  .ANGLE_BITS(ANGLE_BITS)
) u_tst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .turret_angle_i (out_o.turret_angle)
);

// ===== verif/slew_checker.sv =====
`timescale 1ns / 1ps

module slew_checker import tst_pkg::*; #(
  parameter int CFG_W = HOLD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tst_in_if                    in_w,
  tst_out_if                   out_w,
  output int                   err_cnt_o,
  output int                   pending_o,
  output int                   checked_o
);

  localparam int     AW        = ANGLE_BITS_DEF;
  localparam longint TURN      = longint'(1) << AW;
  localparam longint HALF_TURN = longint'(1) << (AW - 1);

  typedef struct packed {
    logic [AW-1:0]        angle;
    logic [SPD_W-1:0]     speed;
    logic signed [AW-1:0] err_left;
    logic                 on_tgt;
    logic                 near_base;
    logic                 speeding_up;
  } turret_pose_t;

  // register copies
  logic              reg_en       = 1'b0;
  logic [SPD_W-1:0]  reg_max_spd  = '0;
  logic [ACC_W-1:0]  reg_accel    = '0;
  logic [SNAP_W-1:0] reg_snap     = SNAP_W'(1);
  logic [TOL_W-1:0]  reg_tol      = '0;
  logic [AW-1:0]     reg_base     = '0;
  logic [HOLD_W-1:0] reg_hold     = '0;

  // turret state
  logic [AW-1:0]    cur_angle = '0;
  logic [SPD_W-1:0] cur_speed = '0;
  int               last_err  = 0;
  int               hold_left = -1;

  turret_pose_t pose_q[$];
  int           mismatches;
  int           compared;

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // shortest signed distance, a half turn counts as negative
  function automatic longint wrap_diff(longint from_a, longint to_a);
    longint d;
    d = (to_a - from_a) & (TURN - 1);
    if (d >= HALF_TURN) d -= TURN;
    return d;
  endfunction

  function automatic turret_pose_t advance_turret(logic [SRC_W-1:0] src, logic [AW-1:0] aim,
                                                  logic reload);
    turret_pose_t p;
    logic   up;
    longint tgt, nd, emag, t8, brake_dist, reach, nspd, move;
    up = 1'b0;
    if (reload) hold_left = int'(reg_hold);
    if (hold_left >= 0) hold_left--;
    if (reg_en) begin
      if (src == SRC_TRACK || src == SRC_FORCE) tgt = longint'(aim);
      else if (hold_left < 0) tgt = longint'(reg_base);
      else tgt = longint'(cur_angle);
      nd   = wrap_diff(longint'(cur_angle), tgt);
      emag = abs_l(longint'(last_err));
      t8   = 0;
      if (reg_accel != 0) t8 = (longint'(cur_speed) << T_FRAC) / longint'(reg_accel);
      // distances scaled by 2^17 so the half in the braking term stays exact
      brake_dist = longint'(cur_speed) * t8 * 512 - longint'(reg_accel) * t8 * t8;
      reach      = (emag * 256 + t8 * emag) * 512;
      up         = brake_dist < reach;
      nspd = up ? longint'(cur_speed) + longint'(reg_accel)
                : longint'(cur_speed) - longint'(reg_accel);
      if (nspd < 0) nspd = 0;
      if (nspd > longint'(reg_max_spd)) nspd = longint'(reg_max_spd);
      cur_speed = SPD_W'(nspd);
      if (abs_l(nd) < longint'(reg_snap)) begin
        cur_angle = AW'(tgt);
        last_err  = 0;
        cur_speed = '0;
      end else begin
        move = (longint'(cur_speed) < abs_l(nd)) ? longint'(cur_speed) : abs_l(nd);
        if (nd <= 0) move = -move;
        cur_angle = AW'((longint'(cur_angle) + move + TURN) & (TURN - 1));
        last_err  = int'(nd - move);
      end
    end
    p.angle       = cur_angle;
    p.speed       = cur_speed;
    p.err_left    = last_err[AW-1:0];
    p.on_tgt      = abs_l(longint'(last_err)) < longint'(reg_tol);
    p.near_base   = abs_l(wrap_diff(longint'(cur_angle), longint'(reg_base)))
                    < longint'(reg_snap);
    p.speeding_up = up;
    return p;
  endfunction

  task automatic cmp_field(input string name, input logic signed [31:0] want,
                           input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    turret_pose_t got, want;
    if (!rst_ni) begin
      reg_en      = 1'b0;
      reg_max_spd = '0;
      reg_accel   = '0;
      reg_snap    = SNAP_W'(1);
      reg_tol     = '0;
      reg_base    = '0;
      reg_hold    = '0;
      cur_angle   = '0;
      cur_speed   = '0;
      last_err    = 0;
      hold_left   = -1;
      pose_q.delete();
      mismatches  = 0;
      compared    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE:       reg_en      = cfg_data_i[0];
          REG_MAX_SPEED:    reg_max_spd = cfg_data_i[SPD_W-1:0];
          REG_ACCELERATION: reg_accel   = cfg_data_i[ACC_W-1:0];
          REG_SNAP_WINDOW:  reg_snap    = cfg_data_i[SNAP_W-1:0];
          REG_TOLERANCE:    reg_tol     = cfg_data_i[TOL_W-1:0];
          REG_BASE_ANGLE:   reg_base    = cfg_data_i[AW-1:0];
          REG_HOLD_TICKS:   reg_hold    = cfg_data_i[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        got.angle       = out_w.turret_angle;
        got.speed       = out_w.turret_speed;
        got.err_left    = out_w.remaining_error;
        got.on_tgt      = out_w.on_target;
        got.near_base   = out_w.at_base;
        got.speeding_up = out_w.accelerating;
        if (pose_q.size() == 0) begin
          $display("%0t: word with nothing expected, expected none, actual angle %0d speed %0d",
                   $time, got.angle, got.speed);
          mismatches++;
        end else begin
          want = pose_q.pop_front();
          cmp_field("turret_angle", want.angle, got.angle);
          cmp_field("turret_speed", want.speed, got.speed);
          cmp_field("remaining_error", want.err_left, got.err_left);
          cmp_field("on_target", want.on_tgt, got.on_tgt);
          cmp_field("at_base", want.near_base, got.near_base);
          cmp_field("accelerating", want.speeding_up, got.speeding_up);
          compared++;
        end
      end
      if (in_w.valid && in_w.ready)
        pose_q.push_back(advance_turret(in_w.aim_source, in_w.aim_angle, in_w.restart_hold));
    end
    err_cnt_o <= mismatches;
    pending_o <= pose_q.size();
    checked_o <= compared;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tst_pkg::*;

  localparam int AW          = ANGLE_BITS_DEF;
  localparam int CFG_W       = (AW > HOLD_W) ? AW : HOLD_W;
  localparam int LIMIT       = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 83;
  // spare source code, the block treats it as no target
  localparam logic [SRC_W-1:0] SRC_SPARE = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int err_cnt, pending, checked;
  int cycles     = 0;
  int stall_left = 0;
  int sink_odds  = 20;
  int src_odds   = 20;
  int n_words    = 0;
  int n_settings = 0;
  bit calm       = 1'b0;

  tst_in_if  in_w ();
  tst_out_if out_w ();

  turret_slew_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_w),
    .out_o      (out_w)
  );

  slew_checker #(.CFG_W(CFG_W)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_w       (in_w),
    .out_w      (out_w),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_w.ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < sink_odds) begin
      stall_left  <= $urandom_range(7);
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= 1'b1;
    end
  end

  // valid stays up after a handshake so back-to-back words never drop it
  task automatic send_word(input logic [SRC_W-1:0] src, input logic [AW-1:0] aim,
                           input logic reload);
    if (!calm && $urandom_range(99) < src_odds) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    in_w.valid        <= 1'b1;
    in_w.aim_source   <= src;
    in_w.aim_angle    <= aim;
    in_w.restart_hold <= reload;
    do @(posedge clk_i); while (!in_w.ready);
    n_words++;
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input int en, input int max_spd, input int accel, input int snap,
                           input int tol, input int base, input int hold);
    put_reg(REG_ENABLE, CFG_W'(en));
    put_reg(REG_MAX_SPEED, CFG_W'(max_spd));
    put_reg(REG_ACCELERATION, CFG_W'(accel));
    put_reg(REG_SNAP_WINDOW, CFG_W'(snap));
    put_reg(REG_TOLERANCE, CFG_W'(tol));
    put_reg(REG_BASE_ANGLE, CFG_W'(base));
    put_reg(REG_HOLD_TICKS, CFG_W'(hold));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // zero, top of range, an oversized value the block masks, or anything in range
  function automatic int pick_val(input int maxv);
    case ($urandom_range(7))
      0: return 0;
      1: return maxv;
      2: return $urandom_range(65535);
      default: return $urandom_range(maxv);
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic random_phase(input int count);
    int               left, len, rate;
    logic [SRC_W-1:0] src;
    logic [AW-1:0]    aim;
    left = count;
    while (left > 0) begin
      len = $urandom_range(20, 4);
      if (len > left) len = left;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          // target drifting at a steady rate, the tracker should follow it
          src  = $urandom_range(1) ? SRC_TRACK : SRC_FORCE;
          aim  = AW'($urandom);
          rate = int'($urandom_range(600)) - 300;
          repeat (len) begin
            send_word(src, aim, $urandom_range(15) == 0);
            aim = aim + AW'(rate);
          end
        end
        6, 7: begin
          // target lost: hold, then return to the rest angle
          for (int i = 0; i < len; i++)
            send_word($urandom_range(3) == 0 ? SRC_SPARE : SRC_NONE, AW'($urandom),
                      i == 0 && $urandom_range(1) == 1);
        end
        default: begin
          repeat (len)
            send_word(SRC_W'($urandom_range(3)), AW'($urandom), 1'($urandom_range(1)));
        end
      endcase
      left -= len;
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_ENABLE;
    cfg_data_i        <= '0;
    in_w.valid        <= 1'b0;
    in_w.aim_source   <= SRC_NONE;
    in_w.aim_angle    <= '0;
    in_w.restart_hold <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // control off after reset: angle held, never accelerating
    send_word(SRC_FORCE, 16'hFFFF, 1'b1);
    send_word(SRC_NONE, 16'h0000, 1'b0);
    drain();

    // fastest settings, no snapping, widest tolerance
    load_regs(1, 8191, 1023, 0, 16383, 16'hFFFF, 3);
    send_word(SRC_FORCE, 16'h8000, 1'b1);
    send_word(SRC_FORCE, 16'h8000, 1'b0);
    send_word(SRC_TRACK, 16'h8000, 1'b0);
    send_word(SRC_TRACK, 16'hFFFF, 1'b0);
    send_word(SRC_SPARE, 16'h1234, 1'b0);
    repeat (4) send_word(SRC_NONE, 16'h0000, 1'b0);
    send_word(SRC_TRACK, 16'h0000, 1'b1);
    send_word(SRC_TRACK, 16'h7FFF, 1'b0);
    drain();

    // no motion allowed, only snapping, zero tolerance
    load_regs(1, 0, 0, 1023, 0, 0, 0);
    send_word(SRC_TRACK, 16'h0100, 1'b0);
    send_word(SRC_TRACK, 16'h7FFF, 1'b0);
    send_word(SRC_NONE, 16'hFFFF, 1'b1);
    send_word(SRC_FORCE, 16'h83FE, 1'b0);
    send_word(SRC_SPARE, 16'h0000, 1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm      = (ph == PHASES - 1);
      sink_odds = calm ? 0 : pick_odds();
      src_odds  = calm ? 0 : pick_odds();
      load_regs($urandom_range(7) != 0, pick_val(8191), pick_val(1023), pick_val(1023),
                pick_val(16383), $urandom_range(65535),
                $urandom_range(7) == 0 ? 65535 : $urandom_range(40));
      random_phase(PHASE_WORDS);
      drain();
    end

    repeat (30) @(posedge clk_i);
    $display("run covered %0d words across %0d register settings", n_words, n_settings);
    $display("%0d results compared, %0d mismatches", checked, err_cnt);
    if (pending != 0)
      $display("%0d predicted results never came", pending);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tst_pkg.sv
hw/rtl/tst_in_if.sv
hw/rtl/tst_out_if.sv
hw/rtl/turret_slew_tracker.sv
hw/rtl/tst_checker.sv
verif/slew_checker.sv
verif/testbench.sv
